// ===== rtl/core/mbps_pkg.sv =====
// Shared types and constants of the masked byte pattern scanner.
package mbps_pkg;

  // Default window depth, which is the longest supported pattern.
  localparam int unsigned MaxPatternDef = 16;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned PatternW = 128;
  localparam int unsigned MaskW    = 16;
  localparam int unsigned LenW     = 5;
  localparam int unsigned OccW     = 32;
  localparam int unsigned AddrW    = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PATTERN_LOW  = 3'd0,
    CFG_PATTERN_HIGH = 3'd1,
    CFG_MASK         = 3'd2,
    CFG_LENGTH       = 3'd3,
    CFG_BASE         = 3'd4,
    CFG_OFFSET       = 3'd5,
    CFG_OCCURRENCE   = 3'd6
  } cfg_idx_e;

  // Settings the scan stage needs.
  typedef struct packed {
    logic [PatternW-1:0] pattern;
    logic [MaskW-1:0]    mask;
    logic [LenW-1:0]     length;
    logic [OccW-1:0]     occurrence;
  } scan_cfg_t;

  // One pending result of the scan stage.
  typedef struct packed {
    logic             found;
    logic [AddrW-1:0] start;
  } scan_res_t;

endpackage

// ===== rtl/core/mbps_cfg_regs.sv =====
// Configuration registers of the masked byte pattern scanner.
module mbps_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_idx_i,
  input  logic [63:0]                cfg_wdata_i,
  output mbps_pkg::scan_cfg_t        cfg_o,
  output logic [63:0]                bias_o
);
  import mbps_pkg::*;

  logic [63:0] pat_lo_q, pat_hi_q, base_q, offset_q, bias_q;
  logic [15:0] mask_q;
  logic [4:0]  len_q;
  logic [31:0] occ_q;

  // The sum of base and offset is kept up to date on every write of either,
  // so the result path needs only one add.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      mask_q   <= '1;
      len_q    <= 5'd1;
      base_q   <= '0;
      offset_q <= '0;
      bias_q   <= '0;
      occ_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PATTERN_LOW:  pat_lo_q <= cfg_wdata_i;
        CFG_PATTERN_HIGH: pat_hi_q <= cfg_wdata_i;
        CFG_MASK:         mask_q   <= cfg_wdata_i[MaskW-1:0];
        CFG_LENGTH:       len_q    <= cfg_wdata_i[LenW-1:0];
        CFG_BASE: begin
          base_q <= cfg_wdata_i;
          bias_q <= cfg_wdata_i + offset_q;
        end
        CFG_OFFSET: begin
          offset_q <= cfg_wdata_i;
          bias_q   <= base_q + cfg_wdata_i;
        end
        CFG_OCCURRENCE:   occ_q    <= cfg_wdata_i[OccW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.pattern    = {pat_hi_q, pat_lo_q};
  assign cfg_o.mask       = mask_q;
  assign cfg_o.length     = len_q;
  assign cfg_o.occurrence = occ_q;
  assign bias_o           = bias_q;

endmodule

// ===== rtl/core/mbps_scan.sv =====
// Input register, byte window, masked compare, match bookkeeping and result register.
module mbps_scan #(
  parameter int unsigned MaxPattern = mbps_pkg::MaxPatternDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mbps_pkg::scan_cfg_t   cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            in_byte_i,
  input  logic                  in_last_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output mbps_pkg::scan_res_t   res_o
);
  import mbps_pkg::*;

  localparam int unsigned IdxW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;

  logic            in_valid_q, in_last_q;
  logic [7:0]      in_byte_q;
  logic [7:0]      win_q [MaxPattern];
  logic [7:0]      win_d [MaxPattern];
  logic [63:0]     seen_q, seen_inc;
  logic [31:0]     matches_q;
  logic            reported_q;
  logic            res_valid_q;
  scan_res_t       res_q, res_d;
  logic            proc_ready, fire, long_enough, match, cand, hit, emit;
  logic [LenW-1:0] eff_len;

  assign proc_ready = !res_valid_q || res_ready_i;
  assign fire       = in_valid_q && proc_ready;
  assign in_ready_o = !in_valid_q || proc_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  // Lengths out of range are clamped into one to MaxPattern.
  always_comb begin
    if (cfg_i.length == '0) begin
      eff_len = LenW'(1);
    end else if (cfg_i.length > LenW'(MaxPattern)) begin
      eff_len = LenW'(MaxPattern);
    end else begin
      eff_len = cfg_i.length;
    end
  end

  // Newest byte sits at position zero.
  always_comb begin
    win_d[0] = in_byte_q;
    for (int k = 1; k < MaxPattern; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  // Pattern byte i lines up with window position eff_len - 1 - i.
  always_comb begin
    logic [LenW-1:0] pos;
    match = 1'b1;
    for (int i = 0; i < MaxPattern; i++) begin
      pos = eff_len - LenW'(1) - LenW'(i);
      if ((LenW'(i) < eff_len) && cfg_i.mask[i] &&
          (win_d[pos[IdxW-1:0]] != cfg_i.pattern[8*i +: 8])) begin
        match = 1'b0;
      end
    end
  end

  assign seen_inc    = (&seen_q) ? seen_q : seen_q + 64'd1;
  assign long_enough = seen_inc >= {{(64-LenW){1'b0}}, eff_len};
  assign cand        = !reported_q && long_enough && match;
  assign hit         = cand && (matches_q == cfg_i.occurrence);
  assign emit        = hit || (in_last_q && !reported_q);

  assign res_d.found = hit;
  assign res_d.start = seen_inc - {{(64-LenW){1'b0}}, eff_len};

  always_ff @(posedge clk_i) begin
    if (fire) begin
      for (int k = 0; k < MaxPattern; k++) begin
        win_q[k] <= win_d[k];
      end
    end
  end

  // A final byte closes the buffer and clears the per-buffer counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= '0;
      matches_q  <= '0;
      reported_q <= 1'b0;
    end else if (fire) begin
      if (in_last_q) begin
        seen_q     <= '0;
        matches_q  <= '0;
        reported_q <= 1'b0;
      end else begin
        seen_q <= seen_inc;
        if (cand && !hit) begin
          matches_q <= matches_q + 32'd1;
        end
        if (hit) begin
          reported_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (proc_ready) begin
      res_valid_q <= fire && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/core/masked_byte_pattern_scanner.sv =====
// Top level of the masked byte pattern scanner: ports, output register, checks.
//
// The scanner takes a buffer one byte per transfer, with tlast on the buffer's
// last byte, and compares a pattern of up to MaxPattern bytes, with a per-byte
// compare mask (a clear bit is a wildcard), against the window of the latest
// bytes. Overlapping matches are counted from zero; match number
// occurrence_index produces one transfer with tuser set and tdata holding the
// match's start offset within the buffer plus base_address plus
// address_offset, modulo 2^64. A buffer that ends without that match produces
// one transfer with tuser clear and tdata zero; other bytes produce nothing,
// and the byte window carries on across buffers. The block takes one byte
// every cycle unless the master side holds it off; the byte that causes a
// result passes the input register and the scan stage, and the result then
// the output register. That rate is set by the scan stage, which updates
// the window and match counters for one byte per cycle. Writes land on the
// clock edge at which cfg_we_i is high: register 0 and 1 hold pattern bytes
// 0-7 and 8-15 (byte 0 in bits 7:0), 2 the compare mask, 3 the pattern
// length, 4 the base address, 5 the signed address offset, 6 the occurrence
// index; index 7 is ignored. Writes belong between buffers or while the
// block holds no pending byte.
module masked_byte_pattern_scanner #(
  parameter int unsigned MaxPattern = mbps_pkg::MaxPatternDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  // Byte stream in.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // final_byte
  // Result stream out.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [63:0] match_address
  output logic        m_axis_tuser_o    // [0] found
);
  import mbps_pkg::*;

  scan_cfg_t   cfg;
  logic [63:0] bias;
  logic        res_valid, out_ready;
  scan_res_t   res;

  logic        out_valid_q, out_found_q;
  logic [63:0] out_addr_q;

  mbps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .bias_o      (bias)
  );

  mbps_scan #(
    .MaxPattern (MaxPattern)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_byte_i   (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .res_valid_o (res_valid),
    .res_ready_i (out_ready),
    .res_o       (res)
  );

  // The output register is free when empty or when its transfer completes,
  // so the scan stage keeps running while a result waits.
  assign out_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= res_valid;
    end
  end

  // The base plus offset is added here; a miss always reports address zero.
  always_ff @(posedge clk_i) begin
    if (out_ready && res_valid) begin
      out_found_q <= res.found;
      out_addr_q  <= res.found ? res.start + bias : '0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_addr_q;
  assign m_axis_tuser_o  = out_found_q;

`ifndef SYNTHESIS
  // Input backpressure only ever comes from a stalled, full output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (out_valid_q && !m_axis_tready_i))
    else $error("input stalled while the output side is free");

  // A not-found result always carries address zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |-> (out_addr_q == '0))
    else $error("not-found result with a nonzero address");

  // The output register fills only from a pending scan result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(res_valid))
    else $error("output became valid without a scan result");
`endif

endmodule

// ===== tb/masked_byte_pattern_scanner_checker.sv =====
`timescale 1ns / 100ps
// Checker for the masked byte pattern scanner: predicts each match report and compares it.
module masked_byte_pattern_scanner_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_tvalid_i,
  input  logic        in_tready_i,
  input  logic [7:0]  in_tdata_i,
  input  logic        in_tlast_i,
  input  logic        out_tvalid_i,
  input  logic        out_tready_i,
  input  logic [63:0] out_tdata_i,
  input  logic        out_tuser_i,
  output int unsigned mismatches_o,
  output int unsigned reports_pending_o,
  output int unsigned found_reports_o,
  output int unsigned missing_reports_o
);
  import mbps_pkg::*;

  typedef struct packed {
    logic             found;
    logic [AddrW-1:0] address;
  } match_report_t;

  // Shadow copy of the register file.
  logic [PatternW-1:0] pattern;
  logic [MaskW-1:0]    mask;
  logic [LenW-1:0]     cfg_length;
  logic [AddrW-1:0]    base;
  logic [AddrW-1:0]    offset;
  logic [OccW-1:0]     occurrence;

  // Scan state: newest byte in window[0].
  logic [7:0]      window [MaxPatternDef];
  logic [63:0]     bytes_seen;
  logic [OccW-1:0] matches_seen;
  logic            reported;

  match_report_t expected_reports [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches_o++;
  endtask

  // Advances the scan by one byte and queues the report it causes, if any.
  function automatic void scan_byte(input logic [7:0] value, input logic last);
    int unsigned   span;
    logic          hit;
    match_report_t rep;
    span = (cfg_length == '0) ? 1 :
           (cfg_length > MaxPatternDef) ? MaxPatternDef : cfg_length;
    for (int i = MaxPatternDef - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = value;
    if (bytes_seen != '1) bytes_seen++;
    hit = !reported && (bytes_seen >= span);
    for (int i = 0; i < span; i++) begin
      if (mask[i] && window[span-1-i] != pattern[8*i +: 8]) hit = 1'b0;
    end
    if (hit) begin
      if (matches_seen == occurrence) begin
        rep.found        = 1'b1;
        rep.address      = bytes_seen - span + base + offset;
        expected_reports = {expected_reports, rep};
        reported         = 1'b1;
      end else begin
        matches_seen++;
      end
    end
    if (last) begin
      if (!reported) begin
        rep.found        = 1'b0;
        rep.address      = '0;
        expected_reports = {expected_reports, rep};
      end
      bytes_seen   = '0;
      matches_seen = '0;
      reported     = 1'b0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    match_report_t want;
    if (!rst_ni) begin
      pattern      = '0;
      mask         = '1;
      cfg_length   = LenW'(1);
      base         = '0;
      offset       = '0;
      occurrence   = '0;
      for (int i = 0; i < MaxPatternDef; i++) window[i] = '0;
      bytes_seen   = '0;
      matches_seen = '0;
      reported     = 1'b0;
      expected_reports.delete();
      mismatches_o      = 0;
      found_reports_o   = 0;
      missing_reports_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PATTERN_LOW:  pattern[63:0]   = cfg_wdata_i;
          CFG_PATTERN_HIGH: pattern[127:64] = cfg_wdata_i;
          CFG_MASK:         mask            = cfg_wdata_i[MaskW-1:0];
          CFG_LENGTH:       cfg_length      = cfg_wdata_i[LenW-1:0];
          CFG_BASE:         base            = cfg_wdata_i;
          CFG_OFFSET:       offset          = cfg_wdata_i;
          CFG_OCCURRENCE:   occurrence      = cfg_wdata_i[OccW-1:0];
          default: ;
        endcase
      end
      if (in_tvalid_i && in_tready_i) scan_byte(in_tdata_i, in_tlast_i);
      if (out_tvalid_i && out_tready_i) begin
        if (expected_reports.size() == 0) begin
          report_mismatch($sformatf("report with none pending: found=%0b address=%h",
                                    out_tuser_i, out_tdata_i));
        end else begin
          want = expected_reports.pop_front();
          if (out_tuser_i !== want.found)
            report_mismatch($sformatf("found flag %0b, predicted %0b",
                                      out_tuser_i, want.found));
          if (out_tdata_i !== want.address)
            report_mismatch($sformatf("match address %h, predicted %h",
                                      out_tdata_i, want.address));
          if (want.found) found_reports_o++;
          else missing_reports_o++;
        end
      end
    end
    reports_pending_o = expected_reports.size();
  end

endmodule

// ===== tb/masked_byte_pattern_scanner_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the masked byte pattern scanner: stimulus, flow control and verdict.
module masked_byte_pattern_scanner_test;
  import mbps_pkg::*;

  localparam int unsigned ItemTarget    = 1850;
  // Extra wait after the last report before touching the registers or ending
  // the run, as a result passes the input, scan and output registers.
  localparam int unsigned DrainCycles   = 4;
  // Length of the receiver's deliberate back-pressure stretch.
  localparam int unsigned LongHold      = 160;
  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned WatchdogLimit = 1000;
  // Register index that the block decodes to nothing.
  localparam logic [2:0]  CfgIdxUnused  = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [63:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_data;
  logic        out_user;

  int unsigned mismatches;
  int unsigned reports_pending;
  int unsigned found_reports;
  int unsigned missing_reports;

  // Stimulus-side view of the current setting, used only to plant pattern
  // copies in the byte stream.
  logic [7:0]  pat [MaxPatternDef];
  logic [15:0] cur_mask;
  int unsigned eff_len;

  int unsigned bytes_sent;
  int unsigned buffers_sent;
  int unsigned settings_used;

  // Flow-control modes: in steady mode a side never idles.
  bit tx_steady;
  bit rx_steady;
  bit hold_request;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  masked_byte_pattern_scanner dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tlast_i  (in_last),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tuser_o  (out_user)
  );

  masked_byte_pattern_scanner_checker report_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_tvalid_i       (in_valid),
    .in_tready_i       (in_ready),
    .in_tdata_i        (in_data),
    .in_tlast_i        (in_last),
    .out_tvalid_i      (out_valid),
    .out_tready_i      (out_ready),
    .out_tdata_i       (out_data),
    .out_tuser_i       (out_user),
    .mismatches_o      (mismatches),
    .reports_pending_o (reports_pending),
    .found_reports_o   (found_reports),
    .missing_reports_o (missing_reports)
  );

  // Offers one byte after a random gap and returns once the transfer has
  // happened. A gap of zero keeps tvalid high straight into the next byte.
  task automatic send_byte(input logic [7:0] value, input logic last);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= value;
    in_last  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Sends a short directed buffer; byte 0 sits in bits 7:0.
  task automatic send_bytes(input logic [127:0] bytes, input int unsigned count);
    for (int unsigned k = 0; k < count; k++) send_byte(bytes[8*k +: 8], k == count - 1);
    buffers_sent++;
  endtask

  // Builds a buffer of the given size from planted pattern copies, pattern
  // bytes and noise, and sends it. Some planted copies get one byte spoiled,
  // so near misses show up next to real matches.
  task automatic scan_buffer(input int unsigned size);
    logic [7:0]  bytes_q [$];
    int unsigned spot;
    while (bytes_q.size() < size) begin
      if ($urandom_range(0, 2) == 0) begin
        for (int unsigned k = 0; k < eff_len; k++)
          bytes_q = {bytes_q, (cur_mask[k] ? pat[k] : 8'($urandom_range(0, 255)))};
        if ($urandom_range(0, 4) == 0) begin
          spot = bytes_q.size() - 1 - $urandom_range(0, eff_len - 1);
          bytes_q[spot] = bytes_q[spot] ^ (8'd1 << $urandom_range(0, 7));
        end
      end else if ($urandom_range(0, 1) == 0) begin
        bytes_q = {bytes_q, pat[$urandom_range(0, eff_len - 1)]};
      end else begin
        bytes_q = {bytes_q, 8'($urandom_range(0, 255))};
      end
    end
    for (int unsigned k = 0; k < size; k++) send_byte(bytes_q[k], k == size - 1);
    buffers_sent++;
  endtask

  // Drops tvalid, waits for every predicted report to arrive, then lets the
  // pipeline drain in case the last bytes produce nothing.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller of a series of writes lowers it.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic configure(input logic [127:0] pattern, input logic [15:0] mask,
                           input logic [4:0] len, input logic [63:0] base,
                           input logic [63:0] offset, input logic [31:0] occurrence);
    write_reg(CFG_PATTERN_LOW, pattern[63:0]);
    write_reg(CFG_PATTERN_HIGH, pattern[127:64]);
    write_reg(CFG_MASK, {48'd0, mask});
    write_reg(CFG_LENGTH, {59'd0, len});
    write_reg(CFG_BASE, base);
    write_reg(CFG_OFFSET, offset);
    write_reg(CFG_OCCURRENCE, {32'd0, occurrence});
    cfg_we <= 1'b0;
    for (int k = 0; k < MaxPatternDef; k++) pat[k] = pattern[8*k +: 8];
    cur_mask = mask;
    eff_len  = (len == 0) ? 1 : (len > MaxPatternDef) ? MaxPatternDef : len;
    settings_used++;
  endtask

  // Receiver: stalls a random number of cycles before each result, with
  // stretches of no stalling, and once per request holds off for a long
  // time so that the scanner backs up into its input.
  initial begin : receiver
    int unsigned stall;
    out_ready = 1'b0;
    rx_steady = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end
      stall = rx_steady ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
    end
  end

  // Watchdog: a hung handshake on either side ends the run.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("No transfer for %0d cycles, %0d reports outstanding.",
             WatchdogLimit, reports_pending);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    logic [127:0] pattern_v;
    logic [15:0]  mask_v;
    logic [4:0]   len_v;
    logic [63:0]  base_v;
    logic [63:0]  offset_v;
    logic [31:0]  occ_v;
    int unsigned  size;
    int unsigned  phase;
    int unsigned  pick;
    bit           squeeze;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_PATTERN_LOW;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_data      = '0;
    in_last      = 1'b0;
    tx_steady    = 1'b0;
    hold_request = 1'b0;
    bytes_sent    = 0;
    buffers_sent  = 0;
    settings_used = 1;
    // Reset setting: pattern byte 0x00, every byte compared, length one.
    for (int k = 0; k < MaxPatternDef; k++) pat[k] = 8'h00;
    cur_mask = 16'hFFFF;
    eff_len  = 1;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // Reset setting: a lone zero byte matches at once, a lone 0xFF does not.
    send_bytes(128'h00, 1);
    send_bytes(128'hFF, 1);

    // Pattern 'x', wildcard, 'x' asking for the second match. The first
    // buffer completes it on its final byte with an address that wraps past
    // 2^64; the second completes it early and then carries on silently
    // through its final byte. The unused register index is written as well.
    wait_idle();
    write_reg(CfgIdxUnused, '1);
    configure(128'h78_FF_78, 16'hFFFD, 5'd3, 64'hFFFF_FFFF_FFFF_FFFE, 64'd5, 32'd1);
    send_bytes(128'h78_11_78_00_78, 5);
    send_bytes(128'h00_78_78_78_78, 5);

    // A length of zero behaves as one; with nothing compared every byte
    // matches, and the most negative offset is applied.
    wait_idle();
    configure(128'h0, 16'h0000, 5'd0, 64'h0, 64'h8000_0000_0000_0000, 32'd2);
    send_bytes(128'hFF_00_01, 3);

    // A length beyond the window behaves as the full window, so a two-byte
    // buffer can only end without a match.
    wait_idle();
    configure('1, 16'hFFFF, 5'd31, '1, 64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_bytes(128'hFF_FF, 2);

    // Random phases: a fresh setting each time, then a handful of buffers
    // seeded with pattern copies. Every seventh phase is a run of tiny
    // buffers sent back to back while the receiver holds off, which fills
    // the scanner up and stalls its input.
    phase = 0;
    while (bytes_sent < ItemTarget) begin
      wait_idle();
      pattern_v = {$urandom, $urandom, $urandom, $urandom};
      pick = $urandom_range(0, 19);
      if (pick == 0) len_v = 5'd0;
      else if (pick == 1) len_v = 5'($urandom_range(17, 31));
      else if (pick < 5) len_v = 5'($urandom_range(7, 16));
      else len_v = 5'($urandom_range(1, 6));
      pick = $urandom_range(0, 9);
      if (pick == 0) mask_v = 16'h0000;
      else if (pick == 1) mask_v = 16'hFFFF;
      else if (pick < 5) mask_v = 16'($urandom);
      else mask_v = ~((16'd1 << $urandom_range(0, 15)) | (16'd1 << $urandom_range(0, 15)));
      pick = $urandom_range(0, 9);
      if (pick == 0) occ_v = 32'hFFFF_FFFF;
      else if (pick == 1) occ_v = $urandom;
      else occ_v = $urandom_range(0, 3);
      pick = $urandom_range(0, 9);
      if (pick == 0) base_v = '0;
      else if (pick == 1) base_v = '1;
      else base_v = {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      if (pick == 0) offset_v = 64'h8000_0000_0000_0000;
      else if (pick == 1) offset_v = 64'h7FFF_FFFF_FFFF_FFFF;
      else if (pick == 2) offset_v = '0;
      else offset_v = {$urandom, $urandom};
      configure(pattern_v, mask_v, len_v, base_v, offset_v, occ_v);

      squeeze = (phase % 7 == 2);
      if (squeeze) begin
        hold_request = 1'b1;
        tx_steady    = 1'b1;
        repeat (30) scan_buffer($urandom_range(1, 2));
      end else begin
        repeat ($urandom_range(3, 8)) begin
          tx_steady = ($urandom_range(0, 3) == 0);
          size = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 48)
                                             : $urandom_range(1, eff_len + 12);
          scan_buffer(size);
        end
      end
      phase++;
    end

    wait_idle();
    $display("Scanned %0d bytes in %0d buffers under %0d register settings.",
             bytes_sent, buffers_sent, settings_used);
    $display("Checked %0d match reports and %0d no-match reports, %0d mismatches.",
             found_reports, missing_reports, mismatches);
    if (mismatches == 0 && reports_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== masked_byte_pattern_scanner.f =====
rtl/core/mbps_pkg.sv
rtl/core/mbps_cfg_regs.sv
rtl/core/mbps_scan.sv
rtl/core/masked_byte_pattern_scanner.sv
tb/masked_byte_pattern_scanner_checker.sv
tb/masked_byte_pattern_scanner_test.sv
